FILE: sv/cld_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the catapult launch detector
// used by cld_core and catapult_launch_detector, no dependencies
package cld_pkg;

    // launch phase codes
    typedef enum logic [1:0] {
        PH_WAITING = 2'd0,
        PH_CONTROL = 2'd1,
        PH_MOTORS  = 2'd2
    } t_phase;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_THR     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_DELAY  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_PRE    = 8'd3;

    // reset values of the configuration registers
    localparam logic signed [15:0] ACCEL_THR_RST   = 16'sd7680;
    localparam logic [31:0]        TIME_THR_RST    = 32'd50000;
    localparam logic [31:0]        MOTOR_DELAY_RST = 32'd0;
    localparam logic signed [15:0] PITCH_PRE_RST   = 16'sd3000;

    localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] accel_threshold;
        logic [31:0]        time_threshold_us;
        logic [31:0]        motor_delay_us;
        logic signed [15:0] pitch_limit_pre_throttle;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] accel_sample;
        logic [23:0]        elapsed_us;
        logic signed [15:0] pitch_limit_default;
        logic               restart;
    } t_item;

    typedef struct packed {
        t_phase             launch_phase;
        logic signed [15:0] pitch_limit;
    } t_result;

    // 32-bit timer plus a 24-bit step, stuck at all ones on overflow
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[32] ? TIME_SAT : s[31:0];
    endfunction

endpackage

FILE: sv/cld_core.sv
`timescale 1ns / 1ps
// launch phase state machine with the two saturating microsecond timers
// depends on cld_pkg
module cld_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  cld_pkg::t_item  i_item,
    input  cld_pkg::t_cfg   i_cfg,
    output cld_pkg::t_result o_res
);
    import cld_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_time, n_time;
    logic [31:0] r_delay, n_delay;
    logic [31:0] w_time_sum;
    logic [31:0] w_delay_sum;

    assign w_time_sum  = sat_add(r_time, i_item.elapsed_us);
    assign w_delay_sum = sat_add(r_delay, i_item.elapsed_us);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAITING;
            r_time  <= '0;
            r_delay <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_time  <= n_time;
            r_delay <= n_delay;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_time  = r_time;
        n_delay = r_delay;
        if (i_item.restart) begin
            n_phase = PH_WAITING;
            n_time  = '0;
            n_delay = '0;
        end else begin
            unique case (r_phase)
                PH_WAITING: begin
                    if (i_item.accel_sample > i_cfg.accel_threshold) begin
                        n_time = w_time_sum;
                        if (w_time_sum > i_cfg.time_threshold_us) begin
                            n_phase = (i_cfg.motor_delay_us != '0) ? PH_CONTROL : PH_MOTORS;
                        end
                    end else begin
                        // at or below threshold, start over
                        n_time  = '0;
                        n_delay = '0;
                    end
                end
                PH_CONTROL: begin
                    n_delay = w_delay_sum;
                    if (w_delay_sum > i_cfg.motor_delay_us) begin
                        n_phase = PH_MOTORS;
                    end
                end
                default: begin
                    // motors enabled holds until restart
                end
            endcase
        end
        o_res.launch_phase = n_phase;
        o_res.pitch_limit  = (n_phase == PH_MOTORS) ? i_item.pitch_limit_default
                                                    : i_cfg.pitch_limit_pre_throttle;
    end

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.restart |=> r_phase == PH_WAITING && r_time == '0 && r_delay == '0)
        else $error("restart did not clear the detector");

    a_motors_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MOTORS && !(i_adv && i_item.restart) |=> r_phase == PH_MOTORS)
        else $error("motors enabled left without restart");

    a_no_delay_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAITING |-> r_delay == '0)
        else $error("delay timer running while waiting");

    a_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_time) && $stable(r_delay))
        else $error("detector state moved without an item");

endmodule

FILE: sv/catapult_launch_detector.sv
`timescale 1ns / 1ps
// Catapult launch detector: one result beat per input beat, in order. Each item passes
// through the input register, then the result register. A new item is accepted every
// cycle and the sustained rate is one item per clock while the result stream is not
// stalled, set by the combinational timer add, compare and phase update in cld_core.
// The output register lets one item wait in the input register while a result is
// stalled. Configuration writes are always accepted and take effect for the next item
// evaluated; indexes above 3 are ignored.
// top level: stream ports, configuration registers, input and result registers
// depends on cld_pkg and cld_core
module catapult_launch_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // accel_sample[15:0], elapsed_us[39:16],
                                        // pitch_limit_default[55:40]
    input  logic [0:0]  s_axis_tuser,   // restart[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // launch_phase[1:0], pitch_limit[17:2], zeros
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cld_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    logic    w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_threshold          <= ACCEL_THR_RST;
            r_cfg.time_threshold_us        <= TIME_THR_RST;
            r_cfg.motor_delay_us           <= MOTOR_DELAY_RST;
            r_cfg.pitch_limit_pre_throttle <= PITCH_PRE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL_THR:   r_cfg.accel_threshold          <= i_cfg_data[15:0];
                CFG_TIME_THR:    r_cfg.time_threshold_us        <= i_cfg_data;
                CFG_MOTOR_DELAY: r_cfg.motor_delay_us           <= i_cfg_data;
                CFG_PITCH_PRE:   r_cfg.pitch_limit_pre_throttle <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item moves to the result register when that one is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.accel_sample        <= s_axis_tdata[15:0];
            r_in.elapsed_us          <= s_axis_tdata[39:16];
            r_in.pitch_limit_default <= s_axis_tdata[55:40];
            r_in.restart             <= s_axis_tuser[0];
        end
    end

    cld_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.pitch_limit, r_out.launch_phase};

    a_out_only_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !w_adv |=> !r_out_valid)
        else $error("result beat appeared without an item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input register accepted over a stalled item");

    a_adv_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> r_in_valid)
        else $error("detector advanced without an item");

endmodule

FILE: test/tb_catapult_launch_detector.sv
`timescale 1ns / 1ps
// testbench for catapult_launch_detector: a directed table, then random launch runs
// every result beat is checked against the table's expected result or an in-bench model of the phase and timer logic
// depends on cld_pkg and catapult_launch_detector
module tb_catapult_launch_detector;
    import cld_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;    // accel_sample, elapsed_us, pitch_limit_default
    logic [0:0]  s_axis_tuser = '0;    // restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // launch_phase, pitch_limit, zeros
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    catapult_launch_detector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // launch model state and its copy of the registers
    t_phase             model_phase = PH_WAITING;
    logic [31:0]        above_us = '0;
    logic [31:0]        delay_us = '0;
    logic signed [15:0] cfg_accel_thr = ACCEL_THR_RST;
    logic [31:0]        cfg_time_thr = TIME_THR_RST;
    logic [31:0]        cfg_motor_delay = MOTOR_DELAY_RST;
    logic signed [15:0] cfg_pitch_pre = PITCH_PRE_RST;

    t_result launch_reports_due[$];
    t_result due;
    int      mismatch_count = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;

    typedef enum {ROW_BEAT, ROW_REG} t_row_kind;
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        t_item                beat;
        bit                   typed;
        t_result              want;
    } t_stim_row;
    t_stim_row stim_rows[$];

    function automatic logic [31:0] timer_add(input logic [31:0] acc, input logic [23:0] step);
        logic [32:0] total;
        total = {1'b0, acc} + {9'd0, step};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic t_result predict_launch(input t_item it);
        t_result r;
        if (it.restart) begin
            model_phase = PH_WAITING;
            above_us = '0;
            delay_us = '0;
        end else if (model_phase == PH_WAITING) begin
            if ($signed(it.accel_sample) > $signed(cfg_accel_thr)) begin
                above_us = timer_add(above_us, it.elapsed_us);
                if (above_us > cfg_time_thr)
                    model_phase = (cfg_motor_delay != 0) ? PH_CONTROL : PH_MOTORS;
            end else begin
                above_us = '0;
                delay_us = '0;
            end
        end else if (model_phase == PH_CONTROL) begin
            delay_us = timer_add(delay_us, it.elapsed_us);
            if (delay_us > cfg_motor_delay)
                model_phase = PH_MOTORS;
        end
        r.launch_phase = model_phase;
        r.pitch_limit = (model_phase == PH_MOTORS) ? it.pitch_limit_default : cfg_pitch_pre;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (launch_reports_due.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(m_axis_tdata), '0);
            end else begin
                due = launch_reports_due.pop_front();
                if (m_axis_tdata[1:0] !== due.launch_phase)
                    report_mismatch("launch_phase", 32'(m_axis_tdata[1:0]),
                                    32'(due.launch_phase));
                if (m_axis_tdata[17:2] !== due.pitch_limit)
                    report_mismatch("pitch_limit", 32'(m_axis_tdata[17:2]),
                                    32'(due.pitch_limit));
                if (m_axis_tdata[23:18] !== '0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[23:18]), '0);
            end
        end
    end

    // called right after an edge; valid stays high from one beat to the next unless an idle gap is drawn
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.pitch_limit_default, it.elapsed_us, it.accel_sample};
        s_axis_tuser <= it.restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_launch(it);
        launch_reports_due.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (launch_reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ACCEL_THR:   cfg_accel_thr = data[15:0];
            CFG_TIME_THR:    cfg_time_thr = data;
            CFG_MOTOR_DELAY: cfg_motor_delay = data;
            CFG_PITCH_PRE:   cfg_pitch_pre = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_pitch();
        case ($urandom_range(0, 9))
            0: return -16'sd18000;
            1: return 16'sd18000;
            default: return 16'($urandom_range(0, 36000) - 18000);
        endcase
    endfunction

    function automatic void add_beat(input int accel, input int dt, input int pdef,
                                     input bit rst, input bit typed, input t_phase ph,
                                     input int lim);
        t_stim_row r;
        r.kind = ROW_BEAT;
        r.idx = '0;
        r.data = '0;
        r.beat.accel_sample = accel[15:0];
        r.beat.elapsed_us = dt[23:0];
        r.beat.pitch_limit_default = pdef[15:0];
        r.beat.restart = rst;
        r.typed = typed;
        r.want.launch_phase = ph;
        r.want.pitch_limit = lim[15:0];
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_stim_row r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        r.beat = '0;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endfunction

    // well-formed runs push above threshold; the rest is noise with stray restarts
    task automatic run_phase(input logic signed [15:0] thr, input logic [31:0] hold_us,
                             input logic [31:0] delay, input logic signed [15:0] pre,
                             input logic [23:0] dt_lo, input logic [23:0] dt_hi,
                             input int seq_min, input int seq_max, input int n_items);
        t_item it;
        int    left;
        int    len;
        int    lo;
        write_reg(CFG_ACCEL_THR, {16'($urandom), thr});
        write_reg(CFG_TIME_THR, hold_us);
        write_reg(CFG_MOTOR_DELAY, delay);
        write_reg(CFG_PITCH_PRE, {16'($urandom), pre});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
        lo = int'(cfg_accel_thr) + 1;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(seq_min, seq_max);
                if (len > left) len = left;
                for (int k = 0; k < len; k++) begin
                    it.restart = (k == 0) && ($urandom_range(0, 3) != 0);
                    // short runs get broken now and then by a sample at or below threshold
                    if (lo > 32767 || (seq_max < 100 && $urandom_range(0, 19) == 0))
                        it.accel_sample = 16'($urandom_range(0, lo + 32767) - 32768);
                    else
                        it.accel_sample = 16'($urandom_range(lo + 32768, 65535) - 32768);
                    it.elapsed_us = 24'($urandom_range(dt_lo, dt_hi));
                    it.pitch_limit_default = rand_pitch();
                    send_item(it, 1'b0, '0);
                end
            end else begin
                len = $urandom_range(1, 6);
                if (len > left) len = left;
                for (int k = 0; k < len; k++) begin
                    it.accel_sample = 16'($urandom);
                    it.elapsed_us = 24'($urandom);
                    it.pitch_limit_default = rand_pitch();
                    it.restart = ($urandom_range(0, 7) == 0);
                    send_item(it, 1'b0, '0);
                end
            end
            left -= len;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values
        add_beat(0, 100, 1234, 0, 1, PH_WAITING, 3000);
        add_beat(32767, 'hFFFFFF, -18000, 1, 1, PH_WAITING, 3000);  // restart drops sample
        add_beat(7680, 'hFFFFFF, 0, 0, 1, PH_WAITING, 3000);        // equal is not above
        add_beat(7681, 50000, 0, 0, 1, PH_WAITING, 3000);           // sum equal to limit
        add_beat(32767, 1, -18000, 0, 1, PH_MOTORS, -18000);        // no delay, straight on
        add_beat(-32768, 0, 18000, 0, 1, PH_MOTORS, 18000);         // motors hold
        add_beat(7681, 500, -7, 0, 0, PH_WAITING, 0);
        add_beat(0, 0, 5, 1, 1, PH_WAITING, 3000);
        // lowest thresholds, short motor delay
        add_reg(CFG_ACCEL_THR, 32'hABCD_8000);
        add_reg(CFG_TIME_THR, 32'd0);
        add_reg(CFG_MOTOR_DELAY, 32'd100);
        add_reg(CFG_PITCH_PRE, 32'h5A5A_B9B0);
        add_reg(CFG_IDX_W'(4), 32'hFFFF_FFFF);
        add_reg(CFG_IDX_W'(255), 32'd0);
        add_beat(-32767, 0, 777, 0, 1, PH_WAITING, -18000);
        add_beat(-32768, 5, 777, 0, 1, PH_WAITING, -18000);
        add_beat(100, 1, 777, 0, 1, PH_CONTROL, -18000);
        add_beat(-32768, 100, 777, 0, 1, PH_CONTROL, -18000);       // delay equal, not over
        add_beat(0, 1, 18000, 0, 1, PH_MOTORS, 18000);
        add_beat(12, 9, -1, 1, 1, PH_WAITING, -18000);
        add_beat(300, 'hABCDEF, 4321, 0, 0, PH_WAITING, 0);
        add_beat(-5, 'h123456, 99, 0, 0, PH_WAITING, 0);
        // highest thresholds
        add_reg(CFG_ACCEL_THR, 32'h0000_7FFF);
        add_reg(CFG_TIME_THR, 32'hFFFF_FFFF);
        add_reg(CFG_MOTOR_DELAY, 32'hFFFF_FFFF);
        add_reg(CFG_PITCH_PRE, 32'h0000_4650);
        add_beat(0, 0, 0, 1, 1, PH_WAITING, 18000);
        add_beat(32767, 'hFFFFFF, 0, 0, 1, PH_WAITING, 18000);
        add_reg(CFG_ACCEL_THR, 32'd0);
        add_beat(1, 'hFFFFFF, -18000, 0, 1, PH_WAITING, 18000);
        add_beat(-1, 'hFFFFFF, 321, 0, 1, PH_WAITING, 18000);

        tx_idle_pct = 10;
        rx_idle_pct = 82;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_REG)
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            else
                send_item(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
        end

        run_phase(ACCEL_THR_RST, TIME_THR_RST, MOTOR_DELAY_RST, PITCH_PRE_RST,
                  24'd1000, 24'd20000, 3, 30, 55);
        run_phase(16'($urandom), $urandom_range(0, 3000),
                  ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(1, 3000),
                  rand_pitch(), 24'd0, 24'd2000, 3, 40, 55);
        // time sum saturates, then just clears a limit below all ones
        run_phase(16'sd0, 32'hFFFF_FFF0, 32'd0, -16'sd18000,
                  24'hFF0000, 24'hFFFFFF, 270, 280, 280);

        tx_idle_pct = 82;
        rx_idle_pct = 10;
        run_phase(-16'sd32768, 32'd0, 32'd1, -16'sd18000, 24'd0, 24'd3, 2, 10, 55);
        run_phase(16'sd32767, $urandom, $urandom, 16'sd18000, 24'd0, 24'hFFFFFF, 3, 20, 55);
        // all-ones time limit is never exceeded
        run_phase(-16'sd100, 32'hFFFF_FFFF, 32'd500, 16'sd1234,
                  24'hFF0000, 24'hFFFFFF, 270, 280, 280);
        run_phase(16'($urandom), $urandom_range(0, 3000),
                  ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(1, 3000),
                  rand_pitch(), 24'd0, 24'd2000, 3, 40, 55);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // all-ones motor delay never ends
        run_phase(16'sd100, 32'd1000, 32'hFFFF_FFFF, rand_pitch(),
                  24'hFF0000, 24'hFFFFFF, 270, 280, 280);
        repeat (2)
            run_phase(16'($urandom), $urandom_range(0, 3000),
                      ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(1, 3000),
                      rand_pitch(), 24'd0, 24'd2000, 3, 40, 55);
        run_phase(16'($urandom), $urandom, $urandom, rand_pitch(),
                  24'd0, 24'hFFFFFF, 3, 20, 55);

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
